@@ sv/pewr_pkg.sv @@
// Package with the types, codes and constants shared by the register-write encoder.
package pewr_pkg;

    // Event kinds.
    typedef enum logic [2:0] {
        KIND_DIRECT   = 3'd0,
        KIND_STEREO   = 3'd1,
        KIND_VOLUME   = 3'd2,
        KIND_NOTE_ON  = 3'd3,
        KIND_NOTE_OFF = 3'd4
    } t_kind;

    // Command bytes.
    localparam logic [7:0] CMD_WRITE_A  = 8'h50;
    localparam logic [7:0] CMD_WRITE_B  = 8'h30;
    localparam logic [7:0] CMD_STEREO_A = 8'h4F;
    localparam logic [7:0] CMD_STEREO_B = 8'h3F;

    // Data byte building blocks.
    localparam logic [7:0] VOL_BASE   = 8'h9F;
    localparam logic [7:0] TONE_LATCH = 8'h80;
    localparam logic [7:0] PAN_BOTH   = 8'h11;
    localparam logic [7:0] PAN_LEFT   = 8'h10;
    localparam logic [7:0] PAN_RIGHT  = 8'h01;

    // Marker for no tone voice latched.
    localparam logic [2:0] LATCH_NONE = 3'd7;

    // Cache sizes.
    localparam int HALVES = 2;
    localparam int VOICES = 8;

    // Writes one event can cause.
    localparam int MAX_WRITES = 3;

    // Default depth of the queue between front and back.
    localparam int JOBQ_DEPTH_DEF = 2;

    // One input event.
    typedef struct packed {
        logic [2:0]         kind;
        logic [1:0]         chip_part;
        logic [2:0]         voice_part;
        logic signed [15:0] value;
    } t_event;

    // One result write.
    typedef struct packed {
        logic [7:0] command_byte;
        logic [7:0] data_byte;
        logic       last_write;
    } t_result;

    // A single command write inside a job.
    typedef struct packed {
        logic [7:0] cmd;
        logic [7:0] data;
    } t_write;

    // All writes of one event, packed from slot 0 upward.
    typedef struct packed {
        logic [1:0]                count;
        t_write [MAX_WRITES-1:0]   slot;
    } t_job;

endpackage

@@ sv/pewr_front.sv @@
// Front end: accepts events, keeps the voice cache and builds the list of writes per event.
module pewr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pewr_pkg::t_event i_event,
    input  logic            i_q_full,
    output logic            o_job_push,
    output pewr_pkg::t_job  o_job
);
    import pewr_pkg::*;

    // Voice cache.
    logic [7:0]  r_stereo_mask [HALVES];
    logic [15:0] r_volume      [VOICES];
    logic [15:0] r_tone        [VOICES];
    logic [VOICES-1:0] r_sounding;
    logic [2:0]  r_latched     [HALVES];

    logic        accept;
    logic        sel_ok;
    logic        half;
    logic [1:0]  voice;
    logic [2:0]  idx;
    logic [2:0]  voice3;
    logic [7:0]  wr_cmd;
    logic [15:0] val;
    logic [15:0] cur_vol;
    logic [15:0] cur_tone;
    logic        cur_snd;
    logic [2:0]  cur_lat;
    logic [7:0]  cur_mask;
    logic [7:0]  voice_bits;

    // Candidate writes in event order.
    logic        ea, eb, ec;
    t_write      wa, wb, wc;

    // Next cache values for the selected entries.
    logic        upd;
    logic [7:0]  n_mask;
    logic        n_mask_en;
    logic [15:0] n_volume;
    logic        n_volume_en;
    logic [15:0] n_tone;
    logic        n_tone_en;
    logic        n_sounding;
    logic        n_sounding_en;
    logic [2:0]  n_latched;

    // Intermediate latch state for note on.
    logic [2:0]  lat1;
    logic [2:0]  lat2;
    logic        tone_wr;
    logic [7:0]  m_clr;

    assign accept = i_push && !i_q_full;
    assign val    = $unsigned(i_event.value);

    // Selector decode: chip half and voice.
    always_comb begin
        sel_ok = (i_event.chip_part <= 2'd1) && (i_event.voice_part <= 3'd5);
        if (i_event.chip_part == 2'd1) begin
            half  = (i_event.voice_part >= 3'd1);
            voice = 2'd3;
        end else begin
            half  = (i_event.voice_part >= 3'd3);
            voice = (i_event.voice_part >= 3'd3) ? 2'(i_event.voice_part - 3'd3)
                                                 : i_event.voice_part[1:0];
        end
        idx        = {half, voice};
        voice3     = {1'b0, voice};
        voice_bits = {1'b0, voice, 5'b0};
        wr_cmd     = half ? CMD_WRITE_B : CMD_WRITE_A;
        cur_vol    = r_volume[idx];
        cur_tone   = r_tone[idx];
        cur_snd    = r_sounding[idx];
        cur_lat    = r_latched[half];
        cur_mask   = r_stereo_mask[half];
    end

    // Per-kind write selection and cache update.
    always_comb begin
        ea            = 1'b0;
        eb            = 1'b0;
        ec            = 1'b0;
        wa            = '{cmd: wr_cmd, data: val[7:0]};
        wb            = '{cmd: wr_cmd, data: TONE_LATCH | {4'b0, val[3:0]} | voice_bits};
        wc            = '{cmd: wr_cmd, data: val[11:4]};
        n_mask        = cur_mask;
        n_mask_en     = 1'b0;
        n_volume      = val;
        n_volume_en   = 1'b0;
        n_tone        = val;
        n_tone_en     = 1'b0;
        n_sounding    = cur_snd;
        n_sounding_en = 1'b0;
        n_latched     = cur_lat;
        lat1          = cur_lat;
        lat2          = cur_lat;
        tone_wr       = 1'b0;
        m_clr         = cur_mask & ~(PAN_BOTH << voice);
        upd           = 1'b0;
        case (i_event.kind)
            KIND_DIRECT: begin
                upd       = 1'b1;
                ea        = 1'b1;
                n_latched = LATCH_NONE;
            end
            KIND_STEREO: begin
                upd    = 1'b1;
                n_mask = m_clr;
                if (val[15] || (val == 16'd0)) begin
                    n_mask = n_mask | (PAN_LEFT << voice);
                end
                if (!val[15]) begin
                    n_mask = n_mask | (PAN_RIGHT << voice);
                end
                if (n_mask != cur_mask) begin
                    ea        = 1'b1;
                    wa        = '{cmd: half ? CMD_STEREO_B : CMD_STEREO_A, data: n_mask};
                    n_mask_en = 1'b1;
                    n_latched = LATCH_NONE;
                end
            end
            KIND_VOLUME: begin
                upd         = 1'b1;
                n_volume_en = 1'b1;
                if (cur_snd && (val != cur_vol)) begin
                    ea        = 1'b1;
                    wa.data   = (VOL_BASE ^ val[7:0]) | voice_bits;
                    n_latched = LATCH_NONE;
                end
            end
            KIND_NOTE_ON: begin
                upd           = 1'b1;
                n_tone_en     = 1'b1;
                n_sounding    = 1'b1;
                n_sounding_en = 1'b1;
                if ((cur_vol != 16'd0) && !cur_snd) begin
                    ea      = 1'b1;
                    wa.data = (VOL_BASE ^ cur_vol[7:0]) | voice_bits;
                    lat1    = LATCH_NONE;
                end
                tone_wr = (val[3:0] != cur_tone[3:0])
                       || ((val != cur_tone) && (lat1 != voice3));
                lat2 = tone_wr ? voice3 : lat1;
                eb   = tone_wr;
                ec   = (lat2 == voice3) && (i_event.chip_part == 2'd0);
                n_latched = lat2;
            end
            KIND_NOTE_OFF: begin
                upd           = 1'b1;
                n_sounding    = 1'b0;
                n_sounding_en = 1'b1;
                if (cur_snd && (cur_vol != 16'd0)) begin
                    ea        = 1'b1;
                    wa.data   = VOL_BASE | voice_bits;
                    n_latched = LATCH_NONE;
                end
            end
            default: begin
                upd = 1'b0;
            end
        endcase
        upd = upd && sel_ok;
    end

    // Pack the enabled writes into the job slots, oldest first.
    always_comb begin
        o_job.count   = 2'({1'b0, ea} + {1'b0, eb} + {1'b0, ec});
        o_job.slot[0] = ea ? wa : (eb ? wb : wc);
        o_job.slot[1] = (ea && eb) ? wb : wc;
        o_job.slot[2] = wc;
        o_job_push    = accept && upd && (o_job.count != 2'd0);
    end

    // Cache registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int h = 0; h < HALVES; h++) begin
                r_stereo_mask[h] <= 8'hFF;
                r_latched[h]     <= LATCH_NONE;
            end
            for (int v = 0; v < VOICES; v++) begin
                r_volume[v] <= 16'hFFFF;
                r_tone[v]   <= 16'hFFFF;
            end
            r_sounding <= '0;
        end else if (accept && upd) begin
            r_latched[half] <= n_latched;
            if (n_mask_en) begin
                r_stereo_mask[half] <= n_mask;
            end
            if (n_volume_en) begin
                r_volume[idx] <= n_volume;
            end
            if (n_tone_en) begin
                r_tone[idx] <= n_tone;
            end
            if (n_sounding_en) begin
                r_sounding[idx] <= n_sounding;
            end
        end
    end

endmodule

@@ sv/pewr_jobq.sv @@
// Short queue of write jobs between the front end and the back end.
module pewr_jobq #(
    parameter int Depth = pewr_pkg::JOBQ_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pewr_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output pewr_pkg::t_job o_job
);
    import pewr_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    t_job            r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CntFull);
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage, written at the tail.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

endmodule

@@ sv/pewr_back.sv @@
// Back end: head-job writes go to the result register one per cycle unless stalled.
module pewr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  pewr_pkg::t_job    i_job,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output pewr_pkg::t_result o_result
);
    import pewr_pkg::*;

    logic [1:0] r_idx;
    logic       r_out_valid;
    t_result    r_out;
    logic       load;
    logic       is_last;
    t_write     cur;

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    // Pick the current write of the head job.
    always_comb begin
        cur     = i_job.slot[r_idx];
        is_last = (r_idx == 2'(i_job.count - 2'd1));
        load    = !i_q_empty && (!r_out_valid || i_pop);
        o_q_pop = load && is_last;
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= '{command_byte: cur.cmd, data_byte: cur.data, last_write: is_last};
        end
    end

    // Write index and result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx       <= is_last ? 2'd0 : r_idx + 2'd1;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ sv/psg_event_to_register_writes.sv @@
// Top level of the sound-chip event to register-write encoder.
//
// Input channel: an event is accepted on a clock edge with i_push high and o_full low.
// Result channel: while o_empty is low, o_result carries the oldest pending write;
// it is taken on a clock edge with i_pop high.
// Each event causes zero to three writes; redundant writes are dropped by the cache,
// and the final write of an event has last_write set.
// An accepted event's writes pass through the job queue, then the result register.
// Throughput: the front end takes one event per cycle while o_full is low; the back
// end sends one write per cycle unless the receiver stalls, taking each event's writes
// in turn. An event that causes no write only updates the cache.
// The job queue between the two parts holds Depth events.
// Reset restores the cache (unset volumes and tones, full stereo masks, no latch)
// and empties the queue and the result register.
// When the receiver stalls, the result holds, the job queue fills and o_full rises.
module psg_event_to_register_writes #(
    parameter int JobqDepth = pewr_pkg::JOBQ_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pewr_pkg::t_event  i_event,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output pewr_pkg::t_result o_result
);
    import pewr_pkg::*;

    t_job job_in;
    t_job job_out;
    logic job_push;
    logic job_pop;
    logic q_full;
    logic q_empty;

    assign o_full = q_full;

    // Event decode and cache.
    pewr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_event    (i_event),
        .i_q_full   (q_full),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    // Job queue.
    pewr_jobq #(
        .Depth (JobqDepth)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (job_out)
    );

    // Write serializer.
    pewr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_job     (job_out),
        .o_q_pop   (job_pop),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_result  (o_result)
    );

endmodule
